@@ hdl/urgent_insert_service_queue_top_macros.svh @@
// Assertion macros for the urgent-insert service queue.
// Included by the top level; no other dependencies.
`ifndef URGENT_INSERT_SERVICE_QUEUE_TOP_MACROS_SVH
`define URGENT_INSERT_SERVICE_QUEUE_TOP_MACROS_SVH

`ifndef SYNTHESIS

// An expression that must hold at every clock edge outside reset.
`define UISQ_ASSERT_HOLDS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("uisq assertion failed");

// A condition that must be followed by a consequence in the next clock cycle.
`define UISQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("uisq assertion failed");

`else

`define UISQ_ASSERT_HOLDS(label, clk, rst, expr)
`define UISQ_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ hdl/uisq_pkg.sv @@
// Package for the urgent-insert service queue: sizes, opcodes and job type.
// Depends on nothing; used by the top level.
`default_nettype none

package uisq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int QCOUNT_W    = 5;

   typedef logic [IDX_W-1:0]    idx_type;
   typedef logic [CNT_W-1:0]    cnt_type;
   typedef logic [CNT_W:0]      sum_type;
   typedef logic [QCOUNT_W-1:0] qcount_type;
   typedef logic [1:0]          op_type;

   localparam op_type OP_NORMAL = 2'd1;
   localparam op_type OP_URGENT = 2'd2;

   typedef struct packed {
      logic [15:0] cls;
      logic [15:0] req;
      logic [7:0]  time_left;
      logic        urgent;
   } job_type;

endpackage

`default_nettype wire

@@ hdl/urgent_insert_service_queue_top.sv @@
// Top level of the urgent-insert service queue: job ring in a synchronous memory.
// Depends on uisq_pkg and urgent_insert_service_queue_top_macros.svh.
`default_nettype none
`include "urgent_insert_service_queue_top_macros.svh"

// Each request transaction is one time tick. A normal job is appended at the
// tail of a ring of uisq_pkg::QUEUE_DEPTH slots, an urgent job is placed
// directly behind the job being served, and then the head job is served: its
// remaining time is reported and decremented, and it leaves the ring when that
// time reaches zero. A job that arrives while the ring is full is dropped and
// flagged. Every request produces exactly one response transaction. The jobs
// live in a single-port-write memory with a registered read; the head slot is
// read in the cycle a request is accepted. A request passes idle and execute
// when the head job leaves the ring or no job is held after the insert, and also
// writeback when a job stays at the head, as its updated entry needs a second write
// through the one write port. The execute step waits for as long as an earlier
// response still sits unaccepted in the output register. The response sits in
// that output register, so it may wait for rsp_ready while the block already
// finishes its memory writes; a new request is taken once the block is back in
// its idle state. The memory contents are undefined after reset and need no
// clearing, since only slots that hold a job are ever used.
module urgent_insert_service_queue_top (
   input  wire  logic        clock,
   input  wire  logic        reset,
   input  wire  logic        req_valid,
   output       logic        req_ready,
   input  wire  logic [1:0]  req_op,
   input  wire  logic [15:0] req_class_id,
   input  wire  logic [15:0] req_requester_id,
   input  wire  logic [7:0]  req_duration,
   output       logic        rsp_valid,
   input  wire  logic        rsp_ready,
   output       logic        rsp_serving,
   output       logic [15:0] rsp_served_requester,
   output       logic [15:0] rsp_served_class,
   output       logic [7:0]  rsp_time_left,
   output       logic        rsp_served_urgent,
   output       logic        rsp_dropped,
   output       logic [4:0]  rsp_queue_count
);

   // Sequencer states: idle (read of the head slot), execute, writeback.
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EXEC  = 2'd1;
   localparam logic [1:0] ST_WRITE = 2'd2;

   logic [1:0]         state_ff, state_in;
   uisq_pkg::idx_type  head_ff, head_in;
   uisq_pkg::cnt_type  count_ff, count_in;

   // The accepted transaction.
   uisq_pkg::op_type   op_ff;
   uisq_pkg::job_type  new_job_ff;

   // Job memory and its registered read port.
   uisq_pkg::job_type  job_mem [uisq_pkg::QUEUE_DEPTH];
   uisq_pkg::job_type  rdata_ff;

   // Deferred writeback of the head job.
   uisq_pkg::idx_type  wb_addr_ff;
   uisq_pkg::job_type  wb_data_ff;

   // Output register.
   logic               rsp_valid_ff;
   logic               rsp_serving_ff;
   logic [15:0]        rsp_requester_ff;
   logic [15:0]        rsp_class_ff;
   logic [7:0]         rsp_time_ff;
   logic               rsp_urgent_ff;
   logic               rsp_dropped_ff;
   uisq_pkg::qcount_type rsp_count_ff;

   logic               out_free;
   logic               exec_fire;
   logic               is_job;
   logic               full;
   logic               insert_ok;
   logic               urgent_mid;
   uisq_pkg::sum_type  tail_sum;
   uisq_pkg::idx_type  tail_idx;
   uisq_pkg::idx_type  prev_idx;
   uisq_pkg::idx_type  head_pos;
   uisq_pkg::idx_type  next_idx;
   uisq_pkg::cnt_type  count_ins;
   uisq_pkg::job_type  head_job;
   logic               have_job;
   logic               serve;
   logic [7:0]         new_time;
   logic               remove;
   logic               wb_en;

   logic               mem_we;
   uisq_pkg::idx_type  mem_waddr;
   uisq_pkg::job_type  mem_wdata;

   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign exec_fire = (state_ff == ST_EXEC) && out_free;

   // Insert and service decisions for the transaction in execute.
   always_comb begin
      is_job     = op_ff inside {uisq_pkg::OP_NORMAL, uisq_pkg::OP_URGENT};
      full       = (count_ff == uisq_pkg::cnt_type'(uisq_pkg::QUEUE_DEPTH));
      insert_ok  = is_job && !full;
      urgent_mid = insert_ok && (op_ff == uisq_pkg::OP_URGENT) && (count_ff != '0);

      // Tail slot is the head plus the count, wrapped around the ring.
      tail_sum = uisq_pkg::sum_type'(head_ff) + uisq_pkg::sum_type'(count_ff);
      if (tail_sum >= uisq_pkg::sum_type'(uisq_pkg::QUEUE_DEPTH)) begin
         tail_sum = tail_sum - uisq_pkg::sum_type'(uisq_pkg::QUEUE_DEPTH);
      end
      tail_idx = uisq_pkg::idx_type'(tail_sum);

      if (head_ff == '0) begin
         prev_idx = uisq_pkg::idx_type'(uisq_pkg::QUEUE_DEPTH - 1);
      end else begin
         prev_idx = head_ff - uisq_pkg::idx_type'(1);
      end

      // An urgent insert moves the current head one slot back and puts the
      // new job into the slot it left.
      head_pos  = urgent_mid ? prev_idx : head_ff;
      count_ins = count_ff + uisq_pkg::cnt_type'(insert_ok);

      // With an empty ring the only candidate for service is the new job.
      head_job = (count_ff == '0) ? new_job_ff : rdata_ff;
      have_job = (count_ins != '0);
      serve    = have_job && (head_job.time_left != 8'd0);
      new_time = head_job.time_left - 8'(serve);
      remove   = have_job && (new_time == 8'd0);
      wb_en    = have_job && !remove;

      if (head_pos == uisq_pkg::idx_type'(uisq_pkg::QUEUE_DEPTH - 1)) begin
         next_idx = '0;
      end else begin
         next_idx = head_pos + uisq_pkg::idx_type'(1);
      end
   end

   // Single write port: the new job in execute, the head job in writeback.
   always_comb begin
      if (state_ff == ST_WRITE) begin
         mem_we    = 1'b1;
         mem_waddr = wb_addr_ff;
         mem_wdata = wb_data_ff;
      end else begin
         mem_we    = exec_fire && insert_ok;
         mem_waddr = urgent_mid ? head_ff : tail_idx;
         mem_wdata = new_job_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      count_in = count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               head_in  = remove ? next_idx : head_pos;
               count_in = count_ins - uisq_pkg::cnt_type'(remove);
               state_in = wb_en ? ST_WRITE : ST_IDLE;
            end
         end
         ST_WRITE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // Transaction capture.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff      <= req_op;
         new_job_ff <= {req_class_id, req_requester_id, req_duration,
                        (req_op == uisq_pkg::OP_URGENT)};
      end
   end

   // Job memory: the head slot is read every cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         job_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= job_mem[head_ff];
   end

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         wb_addr_ff <= head_pos;
         wb_data_ff <= {head_job.cls, head_job.req, new_time, head_job.urgent};
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         rsp_serving_ff   <= serve;
         rsp_requester_ff <= serve ? head_job.req : 16'd0;
         rsp_class_ff     <= serve ? head_job.cls : 16'd0;
         rsp_time_ff      <= serve ? head_job.time_left : 8'd0;
         rsp_urgent_ff    <= serve && head_job.urgent;
         rsp_dropped_ff   <= is_job && full;
         rsp_count_ff     <= uisq_pkg::qcount_type'(count_ins - uisq_pkg::cnt_type'(remove));
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_serving          = rsp_serving_ff;
   assign rsp_served_requester = rsp_requester_ff;
   assign rsp_served_class     = rsp_class_ff;
   assign rsp_time_left        = rsp_time_ff;
   assign rsp_served_urgent    = rsp_urgent_ff;
   assign rsp_dropped          = rsp_dropped_ff;
   assign rsp_queue_count      = rsp_count_ff;

   `UISQ_ASSERT_HOLDS(a_count_bound, clock, reset,
      count_ff <= uisq_pkg::cnt_type'(uisq_pkg::QUEUE_DEPTH))
   `UISQ_ASSERT_NEXT(a_accept_exec, clock, reset,
      req_valid && req_ready, state_ff == ST_EXEC)
   `UISQ_ASSERT_NEXT(a_exec_loads_rsp, clock, reset,
      exec_fire, rsp_valid_ff && (rsp_count_ff == uisq_pkg::qcount_type'(count_ff)))
   `UISQ_ASSERT_HOLDS(a_drop_when_full, clock, reset,
      !(rsp_valid_ff && rsp_dropped_ff) ||
      (count_ff >= uisq_pkg::cnt_type'(uisq_pkg::QUEUE_DEPTH - 1)))

endmodule

`default_nettype wire

@@ tb/sv/tb_urgent_insert_service_queue_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for urgent_insert_service_queue_top: directed table plus random ticks.
// Depends on uisq_pkg and the block's RTL; expected responses come from a job-ring predictor.

module tb_urgent_insert_service_queue_top;

   // Tick-only opcodes; the package names only the two job opcodes.
   localparam uisq_pkg::op_type OP_TICK  = 2'd0;
   localparam uisq_pkg::op_type OP_SPARE = 2'd3;

   localparam int ITEMS_PER_PHASE = 500;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int MAX_REPORTS     = 10;

   // One response transaction, field for field.
   typedef struct packed {
      logic                 serving;
      logic [15:0]          served_requester;
      logic [15:0]          served_class;
      logic [7:0]           time_left;
      logic                 served_urgent;
      logic                 dropped;
      uisq_pkg::qcount_type queue_count;
   } tick_outcome_type;

   // One row of the directed table. Rows with a typed outcome are checked
   // against that outcome; all others against the predictor.
   typedef struct {
      uisq_pkg::op_type op;
      logic [15:0]      cls;
      logic [15:0]      req;
      logic [7:0]       dur;
      bit               typed;
      tick_outcome_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_op = OP_TICK;
   logic [15:0] req_class_id = '0;
   logic [15:0] req_requester_id = '0;
   logic [7:0]  req_duration = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_serving;
   logic [15:0] rsp_served_requester;
   logic [15:0] rsp_served_class;
   logic [7:0]  rsp_time_left;
   logic        rsp_served_urgent;
   logic        rsp_dropped;
   logic [4:0]  rsp_queue_count;

   urgent_insert_service_queue_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_op               (req_op),
      .req_class_id         (req_class_id),
      .req_requester_id     (req_requester_id),
      .req_duration         (req_duration),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_serving          (rsp_serving),
      .rsp_served_requester (rsp_served_requester),
      .rsp_served_class     (rsp_served_class),
      .rsp_time_left        (rsp_time_left),
      .rsp_served_urgent    (rsp_served_urgent),
      .rsp_dropped          (rsp_dropped),
      .rsp_queue_count      (rsp_queue_count)
   );

   always #5 clock = ~clock;

   // Predictor state: the job ring, its head slot and how many jobs it holds.
   uisq_pkg::job_type job_ring [uisq_pkg::QUEUE_DEPTH];
   int      ring_head  = 0;
   int      ring_count = 0;

   // Responses still owed by the block, oldest first.
   tick_outcome_type expected_outcomes [$];

   // The directed table.
   stim_row_type directed [$];

   // Typed outcome of the row being driven, handed from the driver to the monitor.
   bit               cur_typed = 1'b0;
   tick_outcome_type cur_want  = '0;

   // Idle and stall odds in percent per cycle, changed between phases.
   int send_idle_pct  = 6;
   int recv_stall_pct = 69;

   int mismatch_count = 0;
   int cycle_count    = 0;

   // Advances the predicted ring by one tick and returns the response it owes.
   // The new job is placed first, then the head job is served; a head job whose
   // time runs out, or that arrived with none, leaves the ring on this tick.
   function automatic tick_outcome_type service_tick(uisq_pkg::op_type op, logic [15:0] cls,
                                                     logic [15:0] req, logic [7:0] dur);
      tick_outcome_type  o;
      uisq_pkg::job_type nj;
      int                slot;
      o = '0;
      nj.cls       = cls;
      nj.req       = req;
      nj.time_left = dur;
      nj.urgent    = (op == uisq_pkg::OP_URGENT);
      if (op == uisq_pkg::OP_NORMAL || op == uisq_pkg::OP_URGENT) begin
         if (ring_count >= uisq_pkg::QUEUE_DEPTH) begin
            o.dropped = 1'b1;
         end else if (op == uisq_pkg::OP_NORMAL || ring_count == 0) begin
            job_ring[(ring_head + ring_count) % uisq_pkg::QUEUE_DEPTH] = nj;
            ring_count++;
         end else begin
            // The head moves back one slot so that the urgent job sits right
            // behind the job being served.
            slot = (ring_head + uisq_pkg::QUEUE_DEPTH - 1) % uisq_pkg::QUEUE_DEPTH;
            job_ring[slot]      = job_ring[ring_head];
            job_ring[ring_head] = nj;
            ring_head           = slot;
            ring_count++;
         end
      end
      if (ring_count > 0) begin
         if (job_ring[ring_head].time_left != 0) begin
            o.serving          = 1'b1;
            o.served_requester = job_ring[ring_head].req;
            o.served_class     = job_ring[ring_head].cls;
            o.time_left        = job_ring[ring_head].time_left;
            o.served_urgent    = job_ring[ring_head].urgent;
            job_ring[ring_head].time_left--;
         end
         if (job_ring[ring_head].time_left == 0) begin
            ring_head = (ring_head + 1) % uisq_pkg::QUEUE_DEPTH;
            ring_count--;
         end
      end
      o.queue_count = uisq_pkg::qcount_type'(ring_count);
      return o;
   endfunction

   function automatic stim_row_type plain_row(uisq_pkg::op_type op, logic [15:0] cls,
                                              logic [15:0] req, logic [7:0] dur);
      stim_row_type r;
      r.op    = op;
      r.cls   = cls;
      r.req   = req;
      r.dur   = dur;
      r.typed = 1'b0;
      r.want  = '0;
      return r;
   endfunction

   function automatic stim_row_type known_row(uisq_pkg::op_type op, logic [15:0] cls,
                                              logic [15:0] req, logic [7:0] dur,
                                              tick_outcome_type want);
      stim_row_type r;
      r       = plain_row(op, cls, req, dur);
      r.typed = 1'b1;
      r.want  = want;
      return r;
   endfunction

   // Appends one row to the directed table.
   function automatic void add_row(stim_row_type r);
      directed = {directed, r};
   endfunction

   // Drives one request transaction. Called at a falling edge; returns at the
   // falling edge after acceptance. Valid stays high across back-to-back
   // transactions and drops only for an idle gap.
   task automatic send_row(input stim_row_type row);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_op           = row.op;
      req_class_id     = row.cls;
      req_requester_id = row.req;
      req_duration     = row.dur;
      cur_typed        = row.typed;
      cur_want         = row.want;
      req_valid        = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // The receiver stalls at random, independently on every cycle.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Monitor: a request transaction adds its expected response to the queue,
   // and a response transaction is compared with the oldest one waiting. Both
   // are sampled at the rising edge, before the block's own updates land.
   always @(posedge clock) begin
      tick_outcome_type pred;
      tick_outcome_type got;
      tick_outcome_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            pred = service_tick(uisq_pkg::op_type'(req_op), req_class_id, req_requester_id,
                                req_duration);
            expected_outcomes = {expected_outcomes, (cur_typed ? cur_want : pred)};
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_serving, rsp_served_requester, rsp_served_class, rsp_time_left,
                   rsp_served_urgent, rsp_dropped, rsp_queue_count};
            if (expected_outcomes.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("[%0t] response with nothing expected: serving=%0d req=%h cls=%h",
                           $realtime, got.serving, got.served_requester, got.served_class);
            end else begin
               want = expected_outcomes[0];
               expected_outcomes.delete(0);
               if (got.serving !== want.serving ||
                   got.served_requester !== want.served_requester ||
                   got.served_class !== want.served_class ||
                   got.time_left !== want.time_left ||
                   got.served_urgent !== want.served_urgent ||
                   got.dropped !== want.dropped ||
                   got.queue_count !== want.queue_count) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS) begin
                     $display("[%0t] response mismatch", $realtime);
                     $display("   expected serving=%0d req=%h cls=%h left=%0d urg=%0d drop=%0d cnt=%0d",
                              want.serving, want.served_requester, want.served_class,
                              want.time_left, want.served_urgent, want.dropped,
                              want.queue_count);
                     $display("   actual   serving=%0d req=%h cls=%h left=%0d urg=%0d drop=%0d cnt=%0d",
                              got.serving, got.served_requester, got.served_class,
                              got.time_left, got.served_urgent, got.dropped,
                              got.queue_count);
                  end
               end
            end
         end
      end
   end

   // A hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      stim_row_type row;
      bit           fill_mode;
      int           roll;
      int           phase;
      int           n;
      int           k;

      // Directed table. Ticks on an empty ring, the spare opcode, extreme
      // identifiers, an urgent job at an empty ring, zero-duration jobs that
      // leave without service, and a fill to capacity followed by a normal and
      // an urgent job that must both be dropped.
      add_row(known_row(OP_TICK, 16'h0000, 16'h0000, 8'd0,
                        {1'b0, 16'h0000, 16'h0000, 8'd0, 1'b0, 1'b0, 5'd0}));
      add_row(known_row(OP_SPARE, 16'hFFFF, 16'hFFFF, 8'd255,
                        {1'b0, 16'h0000, 16'h0000, 8'd0, 1'b0, 1'b0, 5'd0}));
      add_row(known_row(uisq_pkg::OP_NORMAL, 16'hFFFF, 16'hFFFF, 8'd1,
                        {1'b1, 16'hFFFF, 16'hFFFF, 8'd1, 1'b0, 1'b0, 5'd0}));
      add_row(known_row(uisq_pkg::OP_URGENT, 16'h0000, 16'h0000, 8'd2,
                        {1'b1, 16'h0000, 16'h0000, 8'd2, 1'b1, 1'b0, 5'd1}));
      // This urgent job has no time; it becomes the head as the job ahead of it
      // finishes, and the following tick removes it without service.
      add_row(plain_row(uisq_pkg::OP_URGENT, 16'h5A5A, 16'hA5A5, 8'd0));
      add_row(known_row(OP_TICK, 16'h0000, 16'h0000, 8'd0,
                        {1'b0, 16'h0000, 16'h0000, 8'd0, 1'b0, 1'b0, 5'd0}));
      add_row(known_row(uisq_pkg::OP_NORMAL, 16'h00FF, 16'hFF00, 8'd0,
                        {1'b0, 16'h0000, 16'h0000, 8'd0, 1'b0, 1'b0, 5'd0}));
      add_row(known_row(uisq_pkg::OP_NORMAL, 16'h0000, 16'hFFFF, 8'd255,
                        {1'b1, 16'hFFFF, 16'h0000, 8'd255, 1'b0, 1'b0, 5'd1}));
      for (k = 0; k < 15; k++)
         add_row(plain_row(k[0] ? uisq_pkg::OP_URGENT : uisq_pkg::OP_NORMAL,
                           16'(k * 4099), 16'(16'hFFFF - k * 257), 8'(1 + k * 17)));
      add_row(plain_row(uisq_pkg::OP_NORMAL, 16'h1234, 16'h4321, 8'd9));
      add_row(plain_row(uisq_pkg::OP_URGENT, 16'hBEEF, 16'hCAFE, 8'd3));

      // Synchronous reset, released at a falling edge.
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) send_row(directed[i]);

      // Random part in three phases: a slow receiver, then a slow sender, then
      // both at full rate. Traffic alternates in bursts between filling the ring
      // with mostly short jobs and draining it with ticks, so that full, empty
      // and wrapped states all come around many times.
      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct  = (phase == 0) ? 6 : (phase == 1) ? 69 : 0;
         recv_stall_pct = (phase == 0) ? 69 : (phase == 1) ? 6 : 0;
         fill_mode = 1'b1;
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % 40 == 0) fill_mode = $urandom_range(1);
            roll = $urandom_range(99);
            if (roll < (fill_mode ? 75 : 25))
               row.op = ($urandom_range(99) < 40) ? uisq_pkg::OP_URGENT : uisq_pkg::OP_NORMAL;
            else
               row.op = ($urandom_range(29) == 0) ? OP_SPARE : OP_TICK;
            roll = $urandom_range(9);
            row.cls = (roll == 0) ? 16'h0000 : (roll == 1) ? 16'hFFFF : 16'($urandom);
            roll = $urandom_range(9);
            row.req = (roll == 0) ? 16'h0000 : (roll == 1) ? 16'hFFFF : 16'($urandom);
            roll = $urandom_range(99);
            if (roll < 8)
               row.dur = 8'd0;
            else if (roll < 80)
               row.dur = 8'($urandom_range(3, 1));
            else if (roll < 95)
               row.dur = 8'($urandom_range(30, 4));
            else
               row.dur = 8'($urandom_range(255));
            row.typed = 1'b0;
            row.want  = '0;
            send_row(row);
         end
      end

      // Drain: wait for every owed response, then go on watching so that a
      // stray extra response would still be seen.
      req_valid = 1'b0;
      while (expected_outcomes.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ urgent_insert_service_queue_top.f @@
+incdir+hdl
hdl/uisq_pkg.sv
hdl/urgent_insert_service_queue_top.sv
tb/sv/tb_urgent_insert_service_queue_top.sv
